[sv/ihex_pkg.sv]
// shared types, constants and the hex digit decoder for the intel hex record parser
// no dependencies; used by every other file of the block

package ihex_pkg;

  localparam int unsigned LimitW = 17;
  localparam logic [LimitW-1:0] MemLimitReset = 17'h1_0000;

  // result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_START = 3'd1;
  localparam logic [2:0] ERR_HEX   = 3'd2;
  localparam logic [2:0] ERR_TYPE  = 3'd3;
  localparam logic [2:0] ERR_CHECK = 3'd4;
  localparam logic [2:0] ERR_SHORT = 3'd5;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // record type codes
  localparam logic [7:0] TYPE_DATA = 8'd0;
  localparam logic [7:0] TYPE_EOF  = 8'd1;

  typedef enum logic [7:0] {
    PH_LINE_START = 8'b0000_0001,
    PH_LEN        = 8'b0000_0010,
    PH_ADDR_HI    = 8'b0000_0100,
    PH_ADDR_LO    = 8'b0000_1000,
    PH_TYPE       = 8'b0001_0000,
    PH_DATA       = 8'b0010_0000,
    PH_CHECK      = 8'b0100_0000,
    PH_TRAIL      = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] wr_addr;
    logic [7:0]  wr_byte;
    logic [2:0]  err_code;
    logic [31:0] byte_total;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  function automatic hex_dig_t hex_decode(input logic [7:0] c);
    hex_dig_t d;
    d.ok  = 1'b1;
    d.val = c[3:0];
    if (c >= CH_0 && c <= CH_9) begin
      d.val = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      // letters a-f sit at low nibble 1..6 in both cases
      d.val = 4'(c[3:0] + 4'd9);
    end else begin
      d.ok  = 1'b0;
      d.val = 4'd0;
    end
    return d;
  endfunction

endpackage

[sv/ihex_parser.sv]
// record parser state and per-character next-state and result logic
// depends on ihex_pkg

module ihex_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    ch,
  input  logic [ihex_pkg::LimitW-1:0]   mem_limit,
  output logic                          res_vld,
  output ihex_pkg::res_t                res
);

  ihex_pkg::phase_t phase_r, phase_nxt;
  logic        lo_next_r, lo_next_nxt;
  logic [3:0]  hi_nib_r, hi_nib_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [31:0] total_r, total_nxt;
  logic        halted_r, halted_nxt;

  ihex_pkg::hex_dig_t dig;
  logic [7:0]  byte_val;
  logic [7:0]  idx;
  logic [ihex_pkg::LimitW-1:0] byte_addr;
  logic [7:0]  left_dec;

  always_comb begin
    dig       = ihex_pkg::hex_decode(ch);
    byte_val  = {hi_nib_r, dig.val};
    idx       = 8'(len_r - left_r);
    byte_addr = {1'b0, addr_r} + {{(ihex_pkg::LimitW-8){1'b0}}, idx};
    left_dec  = 8'(left_r - 8'd1);

    phase_nxt   = phase_r;
    lo_next_nxt = lo_next_r;
    hi_nib_nxt  = hi_nib_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    addr_nxt    = addr_r;
    type_nxt    = type_r;
    acc_nxt     = acc_r;
    total_nxt   = total_r;
    halted_nxt  = halted_r;

    res_vld      = 1'b0;
    res.kind     = ihex_pkg::KIND_WRITE;
    res.wr_addr  = 16'd0;
    res.wr_byte  = 8'd0;
    res.err_code = ihex_pkg::ERR_NONE;

    if (step && !halted_r) begin
      if (ch == ihex_pkg::CH_NL || ch == ihex_pkg::CH_NUL) begin
        if (phase_r == ihex_pkg::PH_LINE_START) begin
          // empty line ends the input
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = ihex_pkg::KIND_EOF;
        end else if (phase_r == ihex_pkg::PH_TRAIL) begin
          phase_nxt = ihex_pkg::PH_LINE_START;
        end else begin
          halted_nxt   = 1'b1;
          res_vld      = 1'b1;
          res.kind     = ihex_pkg::KIND_ERROR;
          res.err_code = ihex_pkg::ERR_SHORT;
        end
      end else if (phase_r == ihex_pkg::PH_LINE_START) begin
        if (ch != ihex_pkg::CH_COLON) begin
          halted_nxt   = 1'b1;
          res_vld      = 1'b1;
          res.kind     = ihex_pkg::KIND_ERROR;
          res.err_code = ihex_pkg::ERR_START;
        end else begin
          phase_nxt   = ihex_pkg::PH_LEN;
          acc_nxt     = 8'd0;
          lo_next_nxt = 1'b0;
        end
      end else if (phase_r != ihex_pkg::PH_TRAIL) begin
        if (!dig.ok) begin
          halted_nxt   = 1'b1;
          res_vld      = 1'b1;
          res.kind     = ihex_pkg::KIND_ERROR;
          res.err_code = ihex_pkg::ERR_HEX;
        end else if (!lo_next_r) begin
          hi_nib_nxt  = dig.val;
          lo_next_nxt = 1'b1;
        end else begin
          lo_next_nxt = 1'b0;
          acc_nxt     = 8'(acc_r + byte_val);
          case (phase_r)
            ihex_pkg::PH_LEN: begin
              len_nxt   = byte_val;
              left_nxt  = byte_val;
              phase_nxt = ihex_pkg::PH_ADDR_HI;
            end
            ihex_pkg::PH_ADDR_HI: begin
              addr_nxt  = {byte_val, 8'd0};
              phase_nxt = ihex_pkg::PH_ADDR_LO;
            end
            ihex_pkg::PH_ADDR_LO: begin
              addr_nxt  = {addr_r[15:8], byte_val};
              phase_nxt = ihex_pkg::PH_TYPE;
            end
            ihex_pkg::PH_TYPE: begin
              type_nxt = byte_val;
              if (byte_val > ihex_pkg::TYPE_EOF) begin
                halted_nxt   = 1'b1;
                res_vld      = 1'b1;
                res.kind     = ihex_pkg::KIND_ERROR;
                res.err_code = ihex_pkg::ERR_TYPE;
              end else begin
                phase_nxt = (left_r != 8'd0) ? ihex_pkg::PH_DATA : ihex_pkg::PH_CHECK;
              end
            end
            ihex_pkg::PH_DATA: begin
              left_nxt = left_dec;
              if (left_dec == 8'd0) begin
                phase_nxt = ihex_pkg::PH_CHECK;
              end
              if (type_r == ihex_pkg::TYPE_DATA && byte_addr < mem_limit) begin
                if (total_r != 32'hFFFF_FFFF) begin
                  total_nxt = total_r + 32'd1;
                end
                res_vld     = 1'b1;
                res.kind    = ihex_pkg::KIND_WRITE;
                res.wr_addr = byte_addr[15:0];
                res.wr_byte = byte_val;
              end
            end
            ihex_pkg::PH_CHECK: begin
              phase_nxt = ihex_pkg::PH_TRAIL;
              res_vld   = 1'b1;
              // all record bytes, checksum included, sum to zero
              if (acc_nxt != 8'd0) begin
                halted_nxt   = 1'b1;
                res.kind     = ihex_pkg::KIND_ERROR;
                res.err_code = ihex_pkg::ERR_CHECK;
              end else if (type_r == ihex_pkg::TYPE_EOF) begin
                halted_nxt = 1'b1;
                res.kind   = ihex_pkg::KIND_EOF;
              end else begin
                res.kind = ihex_pkg::KIND_ACCEPT;
              end
            end
            default: begin
              phase_nxt = ihex_pkg::PH_LINE_START;
            end
          endcase
        end
      end
    end

    res.byte_total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ihex_pkg::PH_LINE_START;
      lo_next_r <= 1'b0;
      hi_nib_r  <= 4'd0;
      len_r     <= 8'd0;
      left_r    <= 8'd0;
      addr_r    <= 16'd0;
      type_r    <= 8'd0;
      acc_r     <= 8'd0;
      total_r   <= 32'd0;
      halted_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      lo_next_r <= lo_next_nxt;
      hi_nib_r  <= hi_nib_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      addr_r    <= addr_nxt;
      type_r    <= type_nxt;
      acc_r     <= acc_nxt;
      total_r   <= total_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule

[sv/ihex_out_reg.sv]
// result register between the parser and the result channel
// depends on ihex_pkg

module ihex_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic           res_vld,
  input  ihex_pkg::res_t res,
  input  logic           out_stall,
  output logic           adv,
  output logic           out_valid,
  output ihex_pkg::res_t out_res
);

  logic           vld_r, vld_nxt;
  ihex_pkg::res_t res_r;

  // register can take a new result when empty or when its content transfers now
  assign adv       = !vld_r || !out_stall;
  assign vld_nxt   = adv ? (step && res_vld) : vld_r;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step && res_vld) begin
      res_r <= res;
    end
  end

endmodule

[sv/intel_hex_record_parser_top.sv]
// intel hex record parser: from input transfer to the earliest result transfer a character
// passes the input register, then parser logic into the result register; one character
// per cycle sustained, limited only by result channel stall
// synchronous active-low reset returns to line start, clears counters and the halt
// flag, empties both registers and sets mem_limit to 65536
// depends on ihex_pkg, ihex_parser, ihex_out_reg

module intel_hex_record_parser_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ihex_pkg::LimitW-1:0] cfg_mem_limit,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_ch,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [15:0]                 out_wr_addr,
  output logic [7:0]                  out_wr_byte,
  output logic [2:0]                  out_err_code,
  output logic [31:0]                 out_byte_total
);

  logic [ihex_pkg::LimitW-1:0] limit_r;
  logic                        s1_vld_r, s1_vld_nxt;
  logic [7:0]                  s1_ch_r;
  logic                        adv;
  logic                        step;
  logic                        in_xfer;
  logic                        res_vld;
  ihex_pkg::res_t              res;
  ihex_pkg::res_t              out_res;

  assign step       = s1_vld_r && adv;
  assign in_stall   = s1_vld_r && !adv;
  assign in_xfer    = in_valid && !in_stall;
  assign s1_vld_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= ihex_pkg::MemLimitReset;
      s1_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_mem_limit;
      end
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r <= in_ch;
    end
  end

  ihex_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (s1_ch_r),
    .mem_limit (limit_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  ihex_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_wr_addr    = out_res.wr_addr;
  assign out_wr_byte    = out_res.wr_byte;
  assign out_err_code   = out_res.err_code;
  assign out_byte_total = out_res.byte_total;

  // after an end of file or error transfer nothing more comes out
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall &&
     (out_kind == ihex_pkg::KIND_EOF || out_kind == ihex_pkg::KIND_ERROR))
    |=> !out_valid)
    else $error("result after end of file or error");

  // input side stalls only while the input register holds a character
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a data write result counts itself in the running total
  a_write_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ihex_pkg::KIND_WRITE) |-> (out_byte_total != 32'd0))
    else $error("write result with zero byte total");

endmodule

[test/tb_intel_hex_record_parser_top.sv]
// self-checking testbench for intel_hex_record_parser_top: streams hex file text through
// the character channel and checks every result against an in-bench parser model
// depends on ihex_pkg and the parser rtl

module tb_intel_hex_record_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ihex_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum int {
    END_EOF_REC, END_EMPTY_LINE, END_NO_COLON, END_BAD_DIGIT,
    END_BAD_TYPE, END_BAD_SUM, END_SHORT_LINE
  } finale_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LimitW-1:0] cfg_mem_limit = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_ch = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [15:0] out_wr_addr;
  logic [7:0] out_wr_byte;
  logic [2:0] out_err_code;
  logic [31:0] out_byte_total;

  intel_hex_record_parser_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_mem_limit(cfg_mem_limit),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ch(in_ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_wr_addr(out_wr_addr),
    .out_wr_byte(out_wr_byte),
    .out_err_code(out_err_code),
    .out_byte_total(out_byte_total)
  );

  always #6ns clk = ~clk;

  // parser model state
  phase_t ph = PH_LINE_START;
  bit low_next = 1'b0;
  logic [3:0] hi_nib = '0;
  logic [7:0] rlen = '0;
  logic [7:0] left = '0;
  logic [15:0] raddr = '0;
  logic [7:0] rtype = '0;
  logic [7:0] csum = '0;
  logic [31:0] wtotal = '0;
  bit halted = 1'b0;
  logic [16:0] limit = MemLimitReset;

  res_t results_due[$];
  logic [7:0] char_q[$];
  logic [7:0] rec_bytes[$];
  int chars_in_flight = 0;
  int chars_queued = 0;
  int mismatches = 0;
  int in_gap = 0;
  int stall_left = 0;
  int quiet = 0;
  bit calm = 1'b0;
  res_t seen;
  res_t want;

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void add_result(input logic [1:0] k, input logic [15:0] a,
                                     input logic [7:0] d, input logic [2:0] e);
    res_t r;
    r.kind = k;
    r.wr_addr = a;
    r.wr_byte = d;
    r.err_code = e;
    r.byte_total = wtotal;
    results_due.push_back(r);
  endfunction

  function automatic void stop_with(input logic [2:0] e);
    halted = 1'b1;
    add_result(KIND_ERROR, 16'h0000, 8'h00, e);
  endfunction

  // one character through the parser model
  function automatic void parse_char(input logic [7:0] c);
    int dv;
    logic [7:0] b;
    logic [7:0] idx;
    logic [16:0] addr;
    if (halted) begin
    end else if (c == CH_NL || c == CH_NUL) begin
      if (ph == PH_LINE_START) begin
        halted = 1'b1;
        add_result(KIND_EOF, 16'h0000, 8'h00, ERR_NONE);
      end else if (ph == PH_TRAIL) begin
        ph = PH_LINE_START;
      end else begin
        stop_with(ERR_SHORT);
      end
    end else if (ph == PH_LINE_START) begin
      if (c != CH_COLON) begin
        stop_with(ERR_START);
      end else begin
        ph = PH_LEN;
        csum = '0;
        low_next = 1'b0;
      end
    end else if (ph != PH_TRAIL) begin
      dv = digit_value(c);
      if (dv < 0) begin
        stop_with(ERR_HEX);
      end else if (!low_next) begin
        hi_nib = dv[3:0];
        low_next = 1'b1;
      end else begin
        low_next = 1'b0;
        b = {hi_nib, dv[3:0]};
        csum = csum + b;
        case (ph)
          PH_LEN: begin
            rlen = b;
            left = b;
            ph = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            raddr = {b, 8'h00};
            ph = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            raddr[7:0] = b;
            ph = PH_TYPE;
          end
          PH_TYPE: begin
            rtype = b;
            if (b > TYPE_EOF) stop_with(ERR_TYPE);
            else ph = (left != 0) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            // address runs past 0xffff without wrapping for the limit compare
            idx = rlen - left;
            addr = raddr + idx;
            left = left - 8'd1;
            if (left == 0) ph = PH_CHECK;
            if (rtype == TYPE_DATA && addr < limit) begin
              if (wtotal != 32'hFFFF_FFFF) wtotal = wtotal + 32'd1;
              add_result(KIND_WRITE, addr[15:0], b, ERR_NONE);
            end
          end
          PH_CHECK: begin
            ph = PH_TRAIL;
            if (csum != 8'h00) begin
              stop_with(ERR_CHECK);
            end else if (rtype == TYPE_EOF) begin
              halted = 1'b1;
              add_result(KIND_EOF, 16'h0000, 8'h00, ERR_NONE);
            end else begin
              add_result(KIND_ACCEPT, 16'h0000, 8'h00, ERR_NONE);
            end
          end
          default: ph = PH_LINE_START;
        endcase
      end
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 60);
  endfunction

  function automatic void send_char(input logic [7:0] c);
    char_q.push_back(c);
    chars_in_flight++;
    chars_queued++;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(n - 4'd10);
  endfunction

  function automatic void send_hex(input logic [7:0] b);
    send_char(hex_char(b[7:4]));
    send_char(hex_char(b[3:0]));
  endfunction

  // any character but a line end, optionally never a hex digit
  function automatic logic [7:0] pick_char(input bit hex_ok);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_NL || (!hex_ok && digit_value(c) >= 0)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic void make_record(input logic [7:0] kind_byte, input logic [15:0] addr,
                                      input int len, input logic [7:0] skew);
    logic [7:0] sum;
    rec_bytes.delete();
    rec_bytes.push_back(8'(len));
    rec_bytes.push_back(addr[15:8]);
    rec_bytes.push_back(addr[7:0]);
    rec_bytes.push_back(kind_byte);
    for (int i = 0; i < len; i++) rec_bytes.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (rec_bytes[i]) sum = sum + rec_bytes[i];
    rec_bytes.push_back(8'h00 - sum + skew);
  endfunction

  function automatic void send_prefix(input int n);
    send_char(CH_COLON);
    for (int i = 0; i < n; i++) send_hex(rec_bytes[i]);
  endfunction

  function automatic void line_end();
    send_char(($urandom_range(0, 3) == 0) ? CH_NUL : CH_NL);
  endfunction

  function automatic void send_whole();
    int n;
    send_prefix(rec_bytes.size());
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < n; i++) send_char(($urandom_range(0, 2) == 0) ? CH_CR : pick_char(1'b1));
    line_end();
  endfunction

  task automatic drain();
    while (chars_in_flight != 0 || results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // character driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (char_q.size() != 0) begin
        in_ch <= char_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0) stall_left <= idle_len();
    end
  end

  // monitor: model each character transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        parse_char(in_ch);
        chars_in_flight--;
      end
      if (out_valid && !out_stall) begin
        seen = {out_kind, out_wr_addr, out_wr_byte, out_err_code, out_byte_total};
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d addr %h byte %h err %0d total %0d",
                     seen.kind, seen.wr_addr, seen.wr_byte, seen.err_code, seen.byte_total);
        end else begin
          want = results_due.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch (exp/got): kind %0d/%0d addr %h/%h byte %h/%h err %0d/%0d total %0d/%0d",
                       want.kind, seen.kind, want.wr_addr, seen.wr_addr,
                       want.wr_byte, seen.wr_byte, want.err_code, seen.err_code,
                       want.byte_total, seen.byte_total);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_intel_hex_record_parser_top: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int start;
    int len;
    logic [7:0] c;
    logic [15:0] addr;
    logic [16:0] lim;
    finale_t finale;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top address with a second byte past the end of memory, then an empty record
    make_record(TYPE_DATA, 16'hFFFF, 2, 8'h00);
    send_prefix(rec_bytes.size());
    send_char(8'hFF);
    send_char(CH_NL);
    make_record(TYPE_DATA, 16'h0000, 0, 8'h00);
    send_prefix(rec_bytes.size());
    send_char(CH_NUL);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: lim = 17'h0_0000;
          2: lim = 17'h1_FFFF;
          3: lim = 17'h1_0000;
          4: lim = 17'h0_0001;
          5: lim = 17'($urandom_range(0, 17'h1_FFFF));
          default: lim = 17'($urandom_range(0, 65535));
        endcase
        cfg_mem_limit <= lim;
        cfg_wr_en <= 1'b1;
        limit = lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      calm = (p % 3 == 2);
      start = chars_queued;
      while (chars_queued - start < 220) begin
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
        case ($urandom_range(0, 3))
          0: addr = 16'hFFFF - 16'($urandom_range(0, 40));
          1: addr = limit[15:0] - 16'($urandom_range(0, 20));
          default: addr = 16'($urandom_range(0, 65535));
        endcase
        make_record(TYPE_DATA, addr, len, 8'h00);
        send_whole();
      end
    end

    // the stream ends in exactly one way, then the block must stay silent
    calm = 1'b0;
    addr = 16'($urandom_range(0, 65535));
    finale = finale_t'($urandom_range(0, 6));
    case (finale)
      END_EOF_REC: begin
        make_record(TYPE_EOF, addr, $urandom_range(0, 4), 8'h00);
        send_whole();
      end
      END_EMPTY_LINE: line_end();
      END_NO_COLON: begin
        c = pick_char(1'b1);
        while (c == CH_COLON) c = pick_char(1'b1);
        send_char(c);
      end
      END_BAD_DIGIT: begin
        make_record(TYPE_DATA, addr, 4, 8'h00);
        send_prefix($urandom_range(0, rec_bytes.size() - 1));
        if ($urandom_range(0, 1)) send_char(hex_char(4'($urandom_range(0, 15))));
        send_char($urandom_range(0, 1) ? CH_CR : pick_char(1'b0));
      end
      END_BAD_TYPE: begin
        make_record(8'($urandom_range(2, 255)), addr, $urandom_range(0, 4), 8'h00);
        send_whole();
      end
      END_BAD_SUM: begin
        make_record(TYPE_DATA, addr, $urandom_range(0, 8), 8'($urandom_range(1, 255)));
        send_whole();
      end
      default: begin
        make_record(TYPE_DATA, addr, $urandom_range(0, 6), 8'h00);
        send_prefix($urandom_range(0, rec_bytes.size() - 1));
        if ($urandom_range(0, 1)) send_char(hex_char(4'($urandom_range(0, 15))));
        line_end();
      end
    endcase
    make_record(TYPE_DATA, 16'h0000, 3, 8'h00);
    send_whole();
    for (int i = 0; i < 20; i++) send_char(8'($urandom_range(0, 255)));

    drain();
    if (results_due.size() != 0)
      $display("%0d expected results never arrived", results_due.size());
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_intel_hex_record_parser_top: done, clean");
    end else begin
      $display("tb_intel_hex_record_parser_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/ihex_pkg.sv
sv/ihex_parser.sv
sv/ihex_out_reg.sv
sv/intel_hex_record_parser_top.sv
test/tb_intel_hex_record_parser_top.sv
